/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/lspq_pkg.sv */
package lspq_pkg;

    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int VALUE_W = 32;
    localparam int PRI_W   = 16;
    localparam int OCC_W   = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

/* rtl/lspq_ram.sv */
module lspq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/linear_scan_priority_queue_top.sv */
// Channel | Signals                                        | Transfer
// --------+------------------------------------------------+----------------------
// in      | in_valid, in_ready, action, item_value,        | in_valid & in_ready
//         | item_priority                                  |
// out     | out_valid, out_ready, status, removed_value,   | out_valid & out_ready
//         | removed_priority, occupancy                    |
//
// Insert, clear, the unused action and a delete on an empty queue go from IDLE to DONE.
// Delete-min scans the N stored entries in SCAN through the single RAM read port, then in
// SHIFT moves each entry after the winner at index k down one place (none when k is last).
// Every action ends in DONE, which loads the result into the output register.
// rst_n clears the count and control at once; the RAM needs no clearing pass.
// in_ready is high only while the sequencer is idle; a stalled result holds it in DONE.
`include "assert_macros.svh"

module linear_scan_priority_queue_top import lspq_pkg::*; #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRI_W-1:0]          item_priority,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic signed [VALUE_W-1:0] removed_value,
    output logic [PRI_W-1:0]          removed_priority,
    output logic [OCC_W-1:0]          occupancy
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = VALUE_W + PRI_W;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [AW-1:0]        best_idx_reg, best_idx_next;
    logic [PRI_W-1:0]     best_pri_reg, best_pri_next;
    logic [VALUE_W-1:0]   best_val_reg, best_val_next;
    status_t              res_status_reg, res_status_next;
    logic [VALUE_W-1:0]   res_val_reg, res_val_next;
    logic [PRI_W-1:0]     res_pri_reg, res_pri_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [VALUE_W-1:0]   out_val_reg, out_val_next;
    logic [PRI_W-1:0]     out_pri_reg, out_pri_next;
    logic [OCC_W-1:0]     out_occ_reg, out_occ_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [RW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [RW-1:0]        ram_rdata;
    logic [PRI_W-1:0]     rd_pri;
    logic [VALUE_W-1:0]   rd_val;

    logic                 in_fire;
    logic                 out_free;
    logic                 rd_en;
    logic [CW-1:0]        cmp_idx;
    logic [CW-1:0]        shift_dst;
    action_t              act;

    assign act       = action_t'(action);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign rd_en     = (ptr_reg < count_reg);
    assign cmp_idx   = ptr_reg - CW'(1);
    assign shift_dst = ptr_reg - CW'(2);
    assign rd_pri    = ram_rdata[PRI_W-1:0];
    assign rd_val    = ram_rdata[RW-1:PRI_W];
    assign ram_raddr = ptr_reg[AW-1:0];

    lspq_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (act == ACT_DELETE && count_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!rd_en)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (!rd_en && !rd_pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        rd_pend_next    = rd_pend_reg;
        best_idx_next   = best_idx_reg;
        best_pri_next   = best_pri_reg;
        best_val_next   = best_val_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_pri_next    = res_pri_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_val_next    = out_val_reg;
        out_pri_next    = out_pri_reg;
        out_occ_next    = out_occ_reg;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = {item_value, item_priority};

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next = ST_OK;
                    res_val_next    = '0;
                    res_pri_next    = '0;
                    ptr_next        = '0;
                    rd_pend_next    = 1'b0;
                    unique case (act)
                        ACT_INSERT:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        ACT_NOP:
                        begin
                            res_status_next = ST_OK;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Strict compare keeps the earliest entry on a tie
                if (rd_pend_reg && (cmp_idx == '0 || rd_pri < best_pri_reg))
                begin
                    best_idx_next = cmp_idx[AW-1:0];
                    best_pri_next = rd_pri;
                    best_val_next = rd_val;
                end
                if (rd_en)
                begin
                    ptr_next     = ptr_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    ptr_next     = CW'(best_idx_next) + CW'(1);
                    rd_pend_next = 1'b0;
                    res_val_next = best_val_next;
                    res_pri_next = best_pri_next;
                end
            end
            S_SHIFT:
            begin
                // Write back the entry read last cycle one place lower
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (rd_en)
                begin
                    ptr_next     = ptr_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_val_next    = res_val_reg;
                    out_pri_next    = res_pri_reg;
                    out_occ_next    = OCC_W'(count_reg);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        best_idx_reg   <= best_idx_next;
        best_pri_reg   <= best_pri_next;
        best_val_reg   <= best_val_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_pri_reg    <= res_pri_next;
        out_status_reg <= out_status_next;
        out_val_reg    <= out_val_next;
        out_pri_reg    <= out_pri_next;
        out_occ_reg    <= out_occ_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign removed_value    = out_val_reg;
    assign removed_priority = out_pri_reg;
    assign occupancy        = out_occ_reg;

    `ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_delete_scans, in_fire && act == ACT_DELETE && count_reg != '0, state_reg == S_SCAN)
    `ASSERT_IMPL(a_ptr_bound, state_reg == S_SCAN || state_reg == S_SHIFT, ptr_reg <= count_reg)
    `ASSERT_IMPL(a_full_occ, out_valid_reg && out_status_reg == ST_FULL, out_occ_reg == OCC_W'(QUEUE_DEPTH))

endmodule

/* tb/pq_min_checker.sv */
module pq_min_checker import lspq_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [ACT_W-1:0]          action,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic [PRI_W-1:0]          item_priority,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [STAT_W-1:0]         status,
    input  logic signed [VALUE_W-1:0] removed_value,
    input  logic [PRI_W-1:0]          removed_priority,
    input  logic [OCC_W-1:0]          occupancy,
    output int                        fail_count,
    output int                        pending
);

    typedef struct {
        status_t                   st;
        logic signed [VALUE_W-1:0] val;
        logic [PRI_W-1:0]          pri;
        logic [OCC_W-1:0]          occ;
    } pq_result_t;

    pq_result_t                expected_results[$];
    logic signed [VALUE_W-1:0] queued_value[DEPTH];
    logic [PRI_W-1:0]          queued_prio[DEPTH];
    int                        queued_count;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        queued_count = 0;
    end

    function automatic pq_result_t apply_op(logic [ACT_W-1:0] act,
                                            logic signed [VALUE_W-1:0] value,
                                            logic [PRI_W-1:0] prio);
        pq_result_t r;
        int         best;
        r.st  = ST_OK;
        r.val = '0;
        r.pri = '0;
        case (action_t'(act))
            ACT_INSERT:
            begin
                if (queued_count >= DEPTH)
                begin
                    r.st = ST_FULL;
                end
                else
                begin
                    queued_value[queued_count] = value;
                    queued_prio[queued_count]  = prio;
                    queued_count++;
                end
            end
            ACT_DELETE:
            begin
                if (queued_count == 0)
                begin
                    r.st = ST_EMPTY;
                end
                else
                begin
                    // strict compare keeps the earliest entry on a tie
                    best = 0;
                    for (int i = 1; i < queued_count; i++)
                        if (queued_prio[i] < queued_prio[best])
                            best = i;
                    r.val = queued_value[best];
                    r.pri = queued_prio[best];
                    for (int i = best; i + 1 < queued_count; i++)
                    begin
                        queued_value[i] = queued_value[i + 1];
                        queued_prio[i]  = queued_prio[i + 1];
                    end
                    queued_count--;
                end
            end
            ACT_CLEAR:
            begin
                if (queued_count == 0)
                    r.st = ST_EMPTY;
                else
                    queued_count = 0;
            end
            default:
            begin
            end
        endcase
        r.occ = queued_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(string field, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : watch
        pq_result_t want;
        if (rst_n)
        begin
            // check the result transfer first; no result can stem from a same-edge input
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d occ %0d",
                             $time, status, occupancy);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.st, status);
                    compare_field("removed_value", want.val, removed_value);
                    compare_field("removed_priority", want.pri, removed_priority);
                    compare_field("occupancy", want.occ, occupancy);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_op(action, item_value, item_priority));
            pending = expected_results.size();
        end
    end

endmodule

/* tb/linear_scan_priority_queue_top_tb.sv */
module linear_scan_priority_queue_top_tb;
    import lspq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int RANDOM_OPS  = 1900;
    localparam int TAIL_CYCLES = 2 * QUEUE_DEPTH + 20;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIXED,
        BURST_NOISE
    } burst_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [ACT_W-1:0]          action;
    logic signed [VALUE_W-1:0] item_value;
    logic [PRI_W-1:0]          item_priority;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [PRI_W-1:0]          removed_priority;
    logic [OCC_W-1:0]          occupancy;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;

    linear_scan_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .occupancy        (occupancy)
    );

    pq_min_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .item_value       (item_value),
        .item_priority    (item_priority),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .occupancy        (occupancy),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_op(action_t act, logic signed [VALUE_W-1:0] value,
                           logic [PRI_W-1:0] prio);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        item_value    <= value;
        item_priority <= prio;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // small priorities bunch up to force ties
    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return 16'hFFFF;
            2, 3, 4:    return PRI_W'($urandom_range(0, 7));
            default:    return PRI_W'($urandom);
        endcase
    endfunction

    function automatic action_t pick_action(burst_t b);
        int r;
        r = $urandom_range(0, 99);
        case (b)
            BURST_FILL:
                return (r < 88) ? ACT_INSERT : (r < 98) ? ACT_DELETE : ACT_NOP;
            BURST_DRAIN:
                return (r < 88) ? ACT_DELETE : (r < 97) ? ACT_INSERT :
                       (r < 99) ? ACT_NOP : ACT_CLEAR;
            BURST_MIXED:
                return (r < 50) ? ACT_INSERT : (r < 94) ? ACT_DELETE :
                       (r < 97) ? ACT_CLEAR : ACT_NOP;
            default:
                return action_t'(ACT_W'($urandom_range(0, 3)));
        endcase
    endfunction

    initial
    begin : stimulus
        int      sent;
        int      burst_left;
        int      r;
        burst_t  burst;
        action_t act;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_INSERT;
        item_value    = '0;
        item_priority = '0;
        send_idle_pct = 7;
        recv_idle_pct = 55;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty-queue corners
        send_op(ACT_DELETE, 32'sh1234_5678, 16'h00FF);
        send_op(ACT_CLEAR, -1, 16'hFFFF);
        send_op(ACT_NOP, 32'sh7FFF_FFFF, 16'hFFFF);
        // extremes and ties; the earliest of equal priorities must leave first
        send_op(ACT_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_op(ACT_INSERT, 32'sh8000_0000, 16'h0000);
        send_op(ACT_INSERT, -1, 16'd5);
        send_op(ACT_INSERT, 32'sh0, 16'd5);
        send_op(ACT_INSERT, 32'sh1, 16'h0000);
        send_op(ACT_NOP, 32'sh5555_AAAA, 16'hA5A5);
        send_op(ACT_DELETE, 32'sh0, 16'h0);
        send_op(ACT_DELETE, -1, 16'hFFFF);
        send_op(ACT_DELETE, 32'sh0, 16'h0);
        send_op(ACT_DELETE, 32'sh0, 16'h0);
        send_op(ACT_DELETE, 32'sh0, 16'h0);
        send_op(ACT_DELETE, 32'sh0, 16'h0);
        // clear a populated queue, then reuse it
        send_op(ACT_INSERT, 32'shAAAA_5555, 16'h5A5A);
        send_op(ACT_INSERT, 32'sh5555_AAAA, 16'hA5A5);
        send_op(ACT_CLEAR, 32'sh0, 16'h0);
        send_op(ACT_INSERT, 32'sh0BAD_F00D, 16'h8000);
        send_op(ACT_DELETE, 32'sh0, 16'h0);

        sent       = 0;
        burst_left = 0;
        burst      = BURST_FILL;
        while (sent < RANDOM_OPS)
        begin
            if (sent >= 2 * RANDOM_OPS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent >= RANDOM_OPS / 3)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 7;
            end
            if (burst_left == 0)
            begin
                r = $urandom_range(0, 9);
                burst = (r < 4) ? BURST_FILL : (r < 7) ? BURST_DRAIN :
                        (r < 9) ? BURST_MIXED : BURST_NOISE;
                burst_left = $urandom_range(10, 90);
            end
            act = pick_action(burst);
            send_op(act, pick_value(), pick_priority());
            burst_left--;
            if (act != ACT_NOP)
                sent++;
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
